// ===== rtl/core/ils_pkg.sv =====
// shared constants and types for the indexed lifo stack
`timescale 1ns / 1ps

package ils_pkg;

	// default sizing
	localparam int DEF_STACK_DEPTH = 256;
	localparam int DEF_WORD_WIDTH  = 16;

	// largest number of words that one push carries
	localparam int MAX_PUSH = 5;

	// fixed field widths of the stream payload
	localparam int IN_WORD_W  = 16;
	localparam int OPCODE_W   = 3;
	localparam int COUNT_W    = 3;
	localparam int DEPTH_W    = 8;
	localparam int FILL_W     = 9;
	localparam int STATUS_W   = 2;
	localparam int S_TDATA_W  = 96;
	localparam int S_TUSER_W  = 3;
	localparam int M_TDATA_W  = 32;
	localparam int M_TUSER_W  = 2;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_POP   = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_PEEK  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_POKE  = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STS_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 2'd2;
	localparam logic [STATUS_W-1:0] STS_BAD_DEPTH = 2'd3;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_PUSH,
		S_RESP
	} state_t;

endpackage

// ===== rtl/core/ils_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module ils_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/indexed_lifo_stack.sv =====
// top level of the indexed lifo stack: sequencer, word count and result register
//
// channel  dir  handshake            payload (lowest bit first)
// s_*      in   s_tvalid / s_tready  tuser: opcode; tdata: push_count, word_a..word_e, depth
// m_*      out  m_tvalid / m_tready  tuser: status; tdata: data_out, is_empty, fill
//
// one transaction at a time; the single ram write port sets the cost of a push:
// a push of n >= 2 words writes its deepest word at acceptance, the rest in S_PUSH;
// every other transaction (pop, peek, poke, clear, one-word or zero-count push, failing
// operations) goes straight to S_RESP, which loads the output register, then S_IDLE.
// a result waits in the output register while the next transaction is accepted; the
// result after it holds s_tready low until the register drains.
// arst_n clears the word count and the handshake state; ram contents are not cleared.
`timescale 1ns / 1ps

module indexed_lifo_stack #(
	parameter int STACK_DEPTH = ils_pkg::DEF_STACK_DEPTH,
	parameter int WORD_WIDTH  = ils_pkg::DEF_WORD_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// push_count[2:0], word_a[18:3], word_b[34:19], word_c[50:35], word_d[66:51],
	// word_e[82:67], depth[90:83], zero fill
	input  logic [ils_pkg::S_TDATA_W-1:0]  s_tdata,
	// opcode[2:0]
	input  logic [ils_pkg::S_TUSER_W-1:0]  s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// data_out[15:0], is_empty[16], fill[25:17], zero fill
	output logic [ils_pkg::M_TDATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [ils_pkg::M_TUSER_W-1:0]  m_tuser
);

	import ils_pkg::*;

	localparam int AW   = $clog2(STACK_DEPTH);
	localparam int CW   = $clog2(STACK_DEPTH + 1);
	localparam int SW   = CW + 3;
	localparam int CMPW = (CW > DEPTH_W) ? CW : DEPTH_W;
	localparam int IW   = $clog2(MAX_PUSH);

	// input field split
	logic [OPCODE_W-1:0]   opcode;
	logic [COUNT_W-1:0]    push_count;
	logic [DEPTH_W-1:0]    depth;
	logic [IN_WORD_W-1:0]  in_word [MAX_PUSH];
	logic [WORD_WIDTH-1:0] in_fit [MAX_PUSH];
	logic [COUNT_W-1:0]    n_sat;

	// state
	state_t                state_q, state_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [COUNT_W-1:0]    rem_q, rem_d;
	logic [STATUS_W-1:0]   status_q, status_d;
	logic                  rd_q, rd_d;
	logic [WORD_WIDTH-1:0] words_q [MAX_PUSH];

	// control
	logic                  accept;
	logic                  push_more;
	logic                  load_out;
	logic                  empty;
	logic [SW-1:0]         push_sum;
	logic [CMPW-1:0]       dep_ext, cnt_ext, idx_ext;

	// ram port
	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [WORD_WIDTH-1:0] ram_wdata, ram_rdata;
	logic [WORD_WIDTH+IN_WORD_W-1:0] rdata_ext;
	logic [CW+FILL_W-1:0]  fill_ext;

	// output register
	logic                  m_tvalid_q;
	logic [IN_WORD_W-1:0]  data_q;
	logic                  empty_q;
	logic [FILL_W-1:0]     fill_q;
	logic [STATUS_W-1:0]   mstat_q;

	// payload unpacking
	assign opcode     = s_tuser[OPCODE_W-1:0];
	assign push_count = s_tdata[2:0];
	assign in_word[0] = s_tdata[18:3];
	assign in_word[1] = s_tdata[34:19];
	assign in_word[2] = s_tdata[50:35];
	assign in_word[3] = s_tdata[66:51];
	assign in_word[4] = s_tdata[82:67];
	assign depth      = s_tdata[90:83];

	// fit incoming words to the stored width
	always_comb begin
		logic [WORD_WIDTH+IN_WORD_W-1:0] ext;
		for (int k = 0; k < MAX_PUSH; k++) begin
			ext       = {{WORD_WIDTH{1'b0}}, in_word[k]};
			in_fit[k] = ext[WORD_WIDTH-1:0];
		end
	end

	// push count saturates at five
	assign n_sat = (push_count > COUNT_W'(MAX_PUSH)) ? COUNT_W'(MAX_PUSH) : push_count;

	assign empty    = (cnt_q == '0);
	assign push_sum = SW'(cnt_q) + SW'(n_sat);
	assign dep_ext  = CMPW'(depth);
	assign cnt_ext  = CMPW'(cnt_q);
	assign idx_ext  = cnt_ext - CMPW'(1) - dep_ext;

	assign accept    = s_tvalid & s_tready;
	assign push_more = (opcode == OP_PUSH) && (push_sum <= SW'(STACK_DEPTH))
		&& (n_sat > COUNT_W'(1));
	assign load_out  = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = push_more ? S_PUSH : S_RESP;
				end
			end
			S_PUSH: begin
				if (rem_q == COUNT_W'(1)) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs and ram accesses
	always_comb begin
		s_tready  = (state_q == S_IDLE);
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		cnt_d     = cnt_q;
		rem_d     = rem_q;
		status_d  = status_q;
		rd_d      = rd_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d = STS_OK;
					rd_d     = 1'b0;
					rem_d    = '0;
					case (opcode)
						OP_PUSH: begin
							if (push_sum > SW'(STACK_DEPTH)) begin
								status_d = STS_OVERFLOW;
							end else if (n_sat != '0) begin
								// deepest word goes in first
								ram_we    = 1'b1;
								ram_waddr = cnt_q[AW-1:0];
								ram_wdata = in_fit[IW'(n_sat - COUNT_W'(1))];
								cnt_d     = cnt_q + CW'(1);
								rem_d     = n_sat - COUNT_W'(1);
							end
						end
						OP_POP: begin
							if (empty) begin
								status_d = STS_UNDERFLOW;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = AW'(cnt_q - CW'(1));
								cnt_d     = cnt_q - CW'(1);
								rd_d      = 1'b1;
							end
						end
						OP_PEEK, OP_POKE: begin
							if (empty) begin
								status_d = STS_UNDERFLOW;
							end else if (dep_ext >= cnt_ext) begin
								status_d = STS_BAD_DEPTH;
							end else if (opcode == OP_PEEK) begin
								ram_re    = 1'b1;
								ram_raddr = idx_ext[AW-1:0];
								rd_d      = 1'b1;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = idx_ext[AW-1:0];
								ram_wdata = in_fit[0];
							end
						end
						OP_CLEAR: begin
							cnt_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_PUSH: begin
				// remaining words, one write per cycle
				ram_we    = 1'b1;
				ram_waddr = cnt_q[AW-1:0];
				ram_wdata = words_q[IW'(rem_q - COUNT_W'(1))];
				cnt_d     = cnt_q + CW'(1);
				rem_d     = rem_q - COUNT_W'(1);
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			rem_q    <= '0;
			status_q <= STS_OK;
			rd_q     <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			rem_q    <= rem_d;
			status_q <= status_d;
			rd_q     <= rd_d;
		end
	end

	// push words held for the write sequence
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < MAX_PUSH; k++) begin
				words_q[k] <= in_fit[k];
			end
		end
	end

	// stack storage
	ils_ram #(
		.WIDTH (WORD_WIDTH),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rdata_ext = {{IN_WORD_W{1'b0}}, ram_rdata};
	assign fill_ext  = {{FILL_W{1'b0}}, cnt_q};

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			data_q  <= rd_q ? rdata_ext[IN_WORD_W-1:0] : '0;
			empty_q <= empty;
			fill_q  <= fill_ext[FILL_W-1:0];
			mstat_q <= status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_TDATA_W - IN_WORD_W - 1 - FILL_W){1'b0}}, fill_q, empty_q, data_q};
	assign m_tuser  = mstat_q;

endmodule

// ===== bench/indexed_lifo_stack_tb.sv =====
// self-checking testbench for the indexed lifo stack
`timescale 1ns / 1ps

module indexed_lifo_stack_tb;
	import ils_pkg::*;

	// opcodes the block must treat as no-ops
	localparam logic [OPCODE_W-1:0] OP_SPARE5 = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE7 = 3'd7;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 6;
	localparam int RX_HOLD_CYCLES = 250;
	localparam int IDLE_LIMIT     = 5000;
	localparam int DRAIN_CYCLES   = 12;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic [OPCODE_W-1:0]  op;
		logic [COUNT_W-1:0]   cnt;
		logic [IN_WORD_W-1:0] word_a;
		logic [IN_WORD_W-1:0] word_b;
		logic [IN_WORD_W-1:0] word_c;
		logic [IN_WORD_W-1:0] word_d;
		logic [IN_WORD_W-1:0] word_e;
		logic [DEPTH_W-1:0]   depth;
	} stack_cmd_t;

	typedef struct packed {
		logic [IN_WORD_W-1:0] data;
		logic                 empty;
		logic [FILL_W-1:0]    fill;
		logic [STATUS_W-1:0]  status;
	} stack_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	// shadow copy of the stack
	logic [DEF_WORD_WIDTH-1:0] model_words [DEF_STACK_DEPTH];
	int                        model_level;

	stack_result_t pending_results [$];

	int  errors;
	int  results_checked;
	int  sent_by_op [8];
	int  status_seen [4];
	int  peak_level;
	int  hold_requests;
	bit  no_idle;

	indexed_lifo_stack i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (no_idle || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(3, 1);
		else
			return $urandom_range(25, 6);
	endfunction

	function automatic logic [S_TDATA_W-1:0] pack_cmd(input stack_cmd_t c);
		logic [S_TDATA_W-1:0] v;
		v = '0;
		v[90:0] = {c.depth, c.word_e, c.word_d, c.word_c, c.word_b, c.word_a, c.cnt};
		return v;
	endfunction

	// apply one command to the shadow stack and return the result it must produce
	function automatic stack_result_t apply_stack_op(input stack_cmd_t c);
		stack_result_t        r;
		logic [IN_WORD_W-1:0] words [MAX_PUSH];
		int                   n;
		int                   idx;
		r.data   = '0;
		r.status = STS_OK;
		words    = '{c.word_a, c.word_b, c.word_c, c.word_d, c.word_e};
		case (c.op)
			OP_PUSH: begin
				n = (c.cnt > MAX_PUSH) ? MAX_PUSH : int'(c.cnt);
				if (model_level + n > DEF_STACK_DEPTH) begin
					r.status = STS_OVERFLOW;
				end else begin
					// deepest word goes in first so word_a ends on top
					for (int k = n - 1; k >= 0; k--) begin
						model_words[model_level] = words[k];
						model_level++;
					end
				end
			end
			OP_POP: begin
				if (model_level == 0) begin
					r.status = STS_UNDERFLOW;
				end else begin
					model_level--;
					r.data = model_words[model_level];
				end
			end
			OP_PEEK, OP_POKE: begin
				if (model_level == 0) begin
					r.status = STS_UNDERFLOW;
				end else if (int'(c.depth) >= model_level) begin
					r.status = STS_BAD_DEPTH;
				end else begin
					idx = model_level - 1 - int'(c.depth);
					if (c.op == OP_PEEK)
						r.data = model_words[idx];
					else
						model_words[idx] = c.word_a;
				end
			end
			OP_CLEAR: model_level = 0;
			default: ;
		endcase
		r.empty = (model_level == 0);
		r.fill  = model_level[FILL_W-1:0];
		return r;
	endfunction

	function automatic stack_cmd_t mk_cmd(
		input logic [OPCODE_W-1:0]  op,
		input logic [COUNT_W-1:0]   cnt = 3'd1,
		input logic [DEPTH_W-1:0]   dep = 8'd0,
		input logic [IN_WORD_W-1:0] a = 16'h0000,
		input logic [IN_WORD_W-1:0] b = 16'h0000,
		input logic [IN_WORD_W-1:0] c = 16'h0000,
		input logic [IN_WORD_W-1:0] d = 16'h0000,
		input logic [IN_WORD_W-1:0] e = 16'h0000
	);
		stack_cmd_t v;
		v = '{op, cnt, a, b, c, d, e, dep};
		return v;
	endfunction

	// random command, weighted toward valid depths and legal counts
	function automatic stack_cmd_t random_cmd();
		stack_cmd_t c;
		int         sel;
		sel = $urandom_range(99);
		c.word_a = IN_WORD_W'($urandom_range(16'hFFFF));
		c.word_b = IN_WORD_W'($urandom_range(16'hFFFF));
		c.word_c = IN_WORD_W'($urandom_range(16'hFFFF));
		c.word_d = IN_WORD_W'($urandom_range(16'hFFFF));
		c.word_e = IN_WORD_W'($urandom_range(16'hFFFF));
		if ($urandom_range(9) == 0)
			c.cnt = COUNT_W'($urandom_range(7));
		else
			c.cnt = COUNT_W'($urandom_range(MAX_PUSH, 1));
		if (model_level > 0 && $urandom_range(99) < 80)
			c.depth = DEPTH_W'($urandom_range(model_level - 1));
		else
			c.depth = DEPTH_W'($urandom_range(255));
		if (sel < 38)
			c.op = OP_PUSH;
		else if (sel < 62)
			c.op = OP_POP;
		else if (sel < 78)
			c.op = OP_PEEK;
		else if (sel < 92)
			c.op = OP_POKE;
		else if (sel < 95)
			c.op = OP_CLEAR;
		else
			c.op = OPCODE_W'($urandom_range(OP_SPARE7, OP_SPARE5));
		return c;
	endfunction

	// offer one transaction, wait for it to be taken, then record its result
	task automatic send_cmd(input stack_cmd_t c);
		stack_result_t r;
		int            gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= pack_cmd(c);
		s_tuser  <= c.op;
		do @(posedge clk); while (!s_tready);
		r = apply_stack_op(c);
		pending_results.push_back(r);
		sent_by_op[c.op]++;
		status_seen[r.status]++;
		if (model_level > peak_level)
			peak_level = model_level;
	endtask

	// every operation on an empty stack, spare opcodes and a zero-count push
	task automatic test_empty_stack();
		send_cmd(mk_cmd(OP_POP));
		send_cmd(mk_cmd(OP_PEEK));
		send_cmd(mk_cmd(OP_POKE, 3'd1, 8'd0, 16'hFFFF));
		send_cmd(mk_cmd(OP_CLEAR));
		for (int op = OP_SPARE5; op <= OP_SPARE7; op++)
			send_cmd(mk_cmd(OPCODE_W'(op), 3'd7, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
				16'hFFFF, 16'hFFFF));
		send_cmd(mk_cmd(OP_PUSH, 3'd0, 8'd0, 16'hFFFF));
	endtask

	// push counts across the range, then depth edges for peek and poke
	task automatic test_push_peek_poke();
		send_cmd(mk_cmd(OP_PUSH, 3'd1, 8'd0, 16'hFFFF));
		send_cmd(mk_cmd(OP_PUSH, 3'd5, 8'd0, 16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h8001));
		send_cmd(mk_cmd(OP_PUSH, 3'd7, 8'd0, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h7FFE));
		send_cmd(mk_cmd(OP_PUSH, 3'd6, 8'd0, 16'h0F0F, 16'hF0F0, 16'h3C3C, 16'hC3C3, 16'h0001));
		send_cmd(mk_cmd(OP_PEEK, 3'd0, 8'd0));
		send_cmd(mk_cmd(OP_PEEK, 3'd0, 8'd15));
		send_cmd(mk_cmd(OP_PEEK, 3'd0, 8'd16));
		send_cmd(mk_cmd(OP_PEEK, 3'd0, 8'd255));
		send_cmd(mk_cmd(OP_POKE, 3'd0, 8'd15, 16'hFFFF));
		send_cmd(mk_cmd(OP_POKE, 3'd0, 8'd0, 16'h0000));
		send_cmd(mk_cmd(OP_POKE, 3'd0, 8'd16, 16'hBEEF));
		send_cmd(mk_cmd(OP_PEEK, 3'd0, 8'd15));
		send_cmd(mk_cmd(OP_POP));
		send_cmd(mk_cmd(OP_POP));
		send_cmd(mk_cmd(OP_CLEAR));
		send_cmd(mk_cmd(OP_POP));
	endtask

	// fill to capacity with overflow attempts near the top, work at full, drain part
	task automatic test_fill_to_capacity();
		stack_cmd_t c;
		int         room;
		bit         tried_over;
		tried_over = 1'b0;
		send_cmd(mk_cmd(OP_CLEAR));
		while (model_level < DEF_STACK_DEPTH) begin
			c = random_cmd();
			c.op = OP_PUSH;
			room = DEF_STACK_DEPTH - model_level;
			if (room >= MAX_PUSH) begin
				if ($urandom_range(3) == 0)
					c.cnt = COUNT_W'($urandom_range(MAX_PUSH, 1));
				else
					c.cnt = COUNT_W'(MAX_PUSH);
			end else if (!tried_over) begin
				c.cnt = COUNT_W'($urandom_range(MAX_PUSH, room + 1));
				tried_over = 1'b1;
			end else
				c.cnt = COUNT_W'(room);
			send_cmd(c);
		end
		c = random_cmd();
		send_cmd(mk_cmd(OP_PUSH, 3'd1, 8'd0, c.word_a));
		send_cmd(mk_cmd(OP_PUSH, 3'd0));
		send_cmd(mk_cmd(OP_PEEK, 3'd0, 8'd255));
		send_cmd(mk_cmd(OP_POKE, 3'd0, 8'd255, c.word_b));
		send_cmd(mk_cmd(OP_PEEK, 3'd0, 8'd255));
		send_cmd(mk_cmd(OP_PEEK, 3'd0, 8'd0));
		repeat (60) begin
			c = random_cmd();
			if (c.op == OP_PUSH || c.op == OP_CLEAR)
				c.op = OP_POP;
			send_cmd(c);
		end
		send_cmd(mk_cmd(OP_CLEAR));
	endtask

	task automatic test_random_traffic();
		repeat (340) send_cmd(random_cmd());
	endtask

	// receiver holds off for a long stretch while the sender keeps offering
	task automatic test_output_backpressure();
		no_idle = 1'b1;
		hold_requests++;
		repeat (30) send_cmd(random_cmd());
		no_idle = 1'b0;
	endtask

	// both sides at full rate
	task automatic test_back_to_back();
		no_idle = 1'b1;
		repeat (40) send_cmd(random_cmd());
		no_idle = 1'b0;
	endtask

	// result side: random stalls, long hold on request, compare against oldest prediction
	initial begin : result_sink
		int            stall_left;
		int            hold_left;
		int            holds_taken;
		stack_result_t got;
		stack_result_t want;
		stall_left  = 0;
		hold_left   = 0;
		holds_taken = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[15:0], m_tdata[16], m_tdata[25:17], m_tuser};
				results_checked++;
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected result: data %h empty %0d fill %0d status %0d",
							$realtime, got.data, got.empty, got.fill, got.status);
				end else begin
					want = pending_results.pop_front();
					if (got.data !== want.data || got.empty !== want.empty ||
							got.fill !== want.fill || got.status !== want.status) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: mismatch: expected data %h empty %0d fill %0d status %0d",
								$realtime, want.data, want.empty, want.fill, want.status);
							$display("%0t:           actual data %h empty %0d fill %0d status %0d",
								$realtime, got.data, got.empty, got.fill, got.status);
						end
					end
				end
				stall_left = pick_gap();
			end
			if (holds_taken != hold_requests) begin
				holds_taken++;
				hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ends the run when no transaction moves for too long
	initial begin : watchdog
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
		end
		$display("timeout after %0d cycles without a transaction", IDLE_LIMIT);
		$display("indexed_lifo_stack verification failed");
		$finish;
	end

	// test sequence
	initial begin
		arst_n          = 1'b0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = '0;
		m_tready        = 1'b0;
		model_level     = 0;
		errors          = 0;
		results_checked = 0;
		peak_level      = 0;
		hold_requests   = 0;
		no_idle         = 1'b0;
		foreach (sent_by_op[i]) sent_by_op[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		test_push_peek_poke();
		test_fill_to_capacity();
		test_random_traffic();
		test_output_backpressure();
		test_back_to_back();

		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent push %0d, pop %0d, peek %0d, poke %0d, clear %0d, spare %0d",
			sent_by_op[OP_PUSH], sent_by_op[OP_POP], sent_by_op[OP_PEEK], sent_by_op[OP_POKE],
			sent_by_op[OP_CLEAR],
			sent_by_op[OP_SPARE5] + sent_by_op[OP_SPARE6] + sent_by_op[OP_SPARE7]);
		$display("checked %0d results, peak fill %0d; ok %0d, underflow %0d, overflow %0d",
			results_checked, peak_level, status_seen[STS_OK], status_seen[STS_UNDERFLOW],
			status_seen[STS_OVERFLOW]);
		$display("bad depth %0d; %0d mismatches", status_seen[STS_BAD_DEPTH], errors);
		if (errors == 0)
			$display("indexed_lifo_stack verification clean");
		else
			$display("indexed_lifo_stack verification failed");
		$finish;
	end

endmodule
